/* hdl/gnrc_pkg.sv */
package gnrc_pkg;

  localparam int MAX_DOTS       = 65536;
  localparam int CELL_SLOTS     = 65536;
  localparam int REGIONS        = 64;
  localparam int CELL_SHIFT     = 9;
  localparam int MAX_RADIUS_DEF = 4;

  localparam int COORD_W = 24;
  localparam int SUM_W   = COORD_W + 2;
  localparam int LABEL_W = 6;
  localparam int DOT_W   = $clog2(MAX_DOTS);
  localparam int SLOT_W  = $clog2(CELL_SLOTS);
  localparam int CNT_W   = DOT_W + 1;
  localparam int SQ_W    = 2 * (COORD_W + 1);
  localparam int DIST_W  = SQ_W + 2;

  localparam logic [31:0] HASH_KA = 32'h9E3779B1;
  localparam logic [31:0] HASH_KB = 32'h00009E37;
  localparam logic [31:0] HASH_KC = 32'h85EBCA77;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [DOT_W-1:0]          dot_idx_t;
  typedef logic [LABEL_W-1:0]        label_t;

  typedef struct packed {
    logic   operation;
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    label_t label_region;
  } in_t;

  typedef struct packed {
    logic   found;
    label_t region;
  } out_t;

  typedef struct packed {
    logic             valid;
    coord_t           ka;
    coord_t           kb;
    coord_t           kc;
    dot_idx_t         first;
    dot_idx_t         last;
    logic [CNT_W-1:0] count;
    logic             mixed;
    label_t           uni;
    logic             answered;
    logic             ans_found;
    label_t           ans_region;
  } cell_t;

  typedef struct packed {
    coord_t   x;
    coord_t   y;
    coord_t   z;
    label_t   label;
    dot_idx_t link;
  } dot_t;

  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    cell_t wr_data;
    slot_t rd_addr;
  } cell_req_t;

  typedef struct packed {
    logic     wr_en;
    dot_idx_t wr_addr;
    dot_t     wr_data;
    dot_idx_t rd_addr;
  } dot_req_t;

  // low bits of the multiplicative hash depend only on low operand bits
  function automatic slot_t hash_slot(coord_t a, coord_t b, coord_t c);
    slot_t pa;
    slot_t pb;
    slot_t pc;
    pa = a[SLOT_W-1:0] * HASH_KA[SLOT_W-1:0];
    pb = b[SLOT_W-1:0] * HASH_KB[SLOT_W-1:0];
    pc = c[SLOT_W-1:0] * HASH_KC[SLOT_W-1:0];
    return pa ^ pb ^ pc;
  endfunction

endpackage

/* hdl/gnrc_cell_mem.sv */
module gnrc_cell_mem
  import gnrc_pkg::*;
(
  input  logic      clk,
  input  cell_req_t req,
  output cell_t     rd_data
);

  cell_t mem [CELL_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

/* hdl/gnrc_dot_mem.sv */
module gnrc_dot_mem
  import gnrc_pkg::*;
(
  input  logic     clk,
  input  dot_req_t req,
  output dot_t     rd_data
);

  dot_t mem [MAX_DOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

/* hdl/gnrc_div3.sv */
module gnrc_div3
  import gnrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum_in,
  output logic                    done,
  output coord_t                  quot
);

  localparam int PROD_W   = 2 * SUM_W;
  localparam int RECIP_SH = SUM_W + 1;
  // bias makes the sum non-negative; floor division then shifts by 2^(COORD_W-1)
  localparam logic [SUM_W-1:0] DIV_OFS = SUM_W'(3 * (2 ** (COORD_W - 1)));
  // ceil(2^RECIP_SH / 3); exact floor quotient for every biased sum below 2^SUM_W
  localparam logic [SUM_W-1:0] RECIP   = SUM_W'(((2 ** RECIP_SH) + 2) / 3);

  logic [SUM_W-1:0]   n_r;
  logic [COORD_W-1:0] q_r;
  logic               act_r;
  logic               done_r;
  logic [PROD_W-1:0]  prod;

  assign prod = n_r * RECIP;
  assign done = done_r;
  assign quot = {~q_r[COORD_W-1], q_r[COORD_W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      act_r  <= start;
      done_r <= act_r;
      if (start) begin
        n_r <= $unsigned(sum_in) + DIV_OFS;
      end
      if (act_r) begin
        q_r <= prod[RECIP_SH +: COORD_W];
      end
    end
  end

endmodule

/* hdl/grid_nearest_region_classifier.sv */
// Load: hash the cell key and probe the cell table (one more probe per mismatching slot),
// then write the cell and the dot, plus a link write when the cell already holds dots.
// Query: centroid division, then the home cell lookup (more probes as needed); a uniform or
// answered cell then outputs. Otherwise each scanned neighbor cell is looked up and each of
// its stored dots is read and compared before the finish. One item at a time; a result waits
// in the output register. Reset is synchronous; afterwards a pass clears the cell table.
module grid_nearest_region_classifier
  import gnrc_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int RW = $clog2(MAX_RADIUS + 2) + 1;
  localparam logic signed [RW-1:0] R_ONE = RW'(1);
  localparam logic signed [RW-1:0] R_MAX = RW'(MAX_RADIUS);

  typedef enum logic [15:0] {
    S_CLEAR = 16'b0000000000000001,
    S_IDLE  = 16'b0000000000000010,
    S_DIV   = 16'b0000000000000100,
    S_HASH  = 16'b0000000000001000,
    S_PRD   = 16'b0000000000010000,
    S_PCHK  = 16'b0000000000100000,
    S_DISP  = 16'b0000000001000000,
    S_LDWR  = 16'b0000000010000000,
    S_LINK  = 16'b0000000100000000,
    S_NBR   = 16'b0000001000000000,
    S_DRD   = 16'b0000010000000000,
    S_DMUL  = 16'b0000100000000000,
    S_DCMP  = 16'b0001000000000000,
    S_NEXT  = 16'b0010000000000000,
    S_FIN   = 16'b0100000000000000,
    S_RESP  = 16'b1000000000000000
  } state_t;

  state_t state_r;
  slot_t  clr_r;
  logic   op_r;
  coord_t px_r, py_r, pz_r;
  label_t lbl_r;
  coord_t bi_r, bj_r, bk_r;
  coord_t ka_r, kb_r, kc_r;
  logic   create_r;
  logic   hit_r;
  slot_t  slot_r;
  slot_t  pcnt_r;
  cell_t  cell_r;
  logic   here_ok_r;
  slot_t  here_slot_r;
  cell_t  here_cell_r;
  logic [CNT_W-1:0] dots_r;
  logic signed [RW-1:0] rad_r, di_r, dj_r, dk_r;
  dot_idx_t cur_dot_r;
  logic [CNT_W-1:0] k_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  label_t   dlbl_r;
  dot_idx_t dlink_r;
  logic     got_r;
  logic [DIST_W-1:0] best_d_r;
  label_t   best_r_r;
  out_t     res_r;
  out_t     out_r;
  logic     out_valid_r;

  cell_req_t cell_req;
  dot_req_t  dot_req;
  cell_t     cell_rd;
  dot_t      dot_rd;
  cell_t     fresh;
  cell_t     ld_cell;
  cell_t     fin_cell;
  dot_t      link_dot;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  coord_t qx, qy, qz;
  logic [2:0] div_done;
  logic div_start;
  logic accept;
  logic key_hit;

  logic signed [COORD_W:0] ex, ey, ez;
  logic [DIST_W-1:0] e_sum;
  logic signed [RW-1:0] neg_rad;
  logic interior_ij;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && (in_data.operation == OP_QUERY);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sum_x = SUM_W'(in_data.v0_x) + SUM_W'(in_data.v1_x) + SUM_W'(in_data.v2_x);
  assign sum_y = SUM_W'(in_data.v0_y) + SUM_W'(in_data.v1_y) + SUM_W'(in_data.v2_y);
  assign sum_z = SUM_W'(in_data.v0_z) + SUM_W'(in_data.v1_z) + SUM_W'(in_data.v2_z);

  gnrc_div3 u_div_x (.clk, .rst_n, .start(div_start), .sum_in(sum_x),
                     .done(div_done[0]), .quot(qx));
  gnrc_div3 u_div_y (.clk, .rst_n, .start(div_start), .sum_in(sum_y),
                     .done(div_done[1]), .quot(qy));
  gnrc_div3 u_div_z (.clk, .rst_n, .start(div_start), .sum_in(sum_z),
                     .done(div_done[2]), .quot(qz));

  gnrc_cell_mem u_cell_mem (.clk, .req(cell_req), .rd_data(cell_rd));
  gnrc_dot_mem  u_dot_mem  (.clk, .req(dot_req),  .rd_data(dot_rd));

  assign key_hit = (cell_rd.ka == ka_r) && (cell_rd.kb == kb_r) && (cell_rd.kc == kc_r);

  assign ex = (COORD_W+1)'(px_r) - (COORD_W+1)'(dot_rd.x);
  assign ey = (COORD_W+1)'(py_r) - (COORD_W+1)'(dot_rd.y);
  assign ez = (COORD_W+1)'(pz_r) - (COORD_W+1)'(dot_rd.z);
  assign e_sum = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);

  assign neg_rad     = -rad_r;
  assign interior_ij = (rad_r > R_ONE) && (di_r > neg_rad) && (di_r < rad_r) &&
                       (dj_r > neg_rad) && (dj_r < rad_r);

  always_comb begin
    fresh       = '0;
    fresh.valid = 1'b1;
    fresh.ka    = ka_r;
    fresh.kb    = kb_r;
    fresh.kc    = kc_r;

    ld_cell = cell_r;
    if (cell_r.count == '0) begin
      ld_cell.first = dots_r[DOT_W-1:0];
      ld_cell.uni   = lbl_r;
    end else if (cell_r.uni != lbl_r) begin
      ld_cell.mixed = 1'b1;
    end
    ld_cell.last  = dots_r[DOT_W-1:0];
    ld_cell.count = cell_r.count + CNT_W'(1);

    fin_cell            = here_cell_r;
    fin_cell.answered   = 1'b1;
    fin_cell.ans_found  = got_r;
    fin_cell.ans_region = got_r ? best_r_r : '0;

    link_dot      = dot_rd;
    link_dot.link = DOT_W'(dots_r - CNT_W'(1));
  end

  always_comb begin
    cell_req         = '0;
    cell_req.rd_addr = slot_r;
    dot_req          = '0;
    dot_req.rd_addr  = (state_r == S_LDWR) ? cell_r.last : cur_dot_r;
    unique case (state_r)
      S_CLEAR: begin
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = clr_r;
      end
      S_PCHK: begin
        cell_req.wr_en   = !cell_rd.valid && create_r;
        cell_req.wr_addr = slot_r;
        cell_req.wr_data = fresh;
      end
      S_LDWR: begin
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = slot_r;
        cell_req.wr_data = ld_cell;
        dot_req.wr_en    = 1'b1;
        dot_req.wr_addr  = dots_r[DOT_W-1:0];
        dot_req.wr_data  = '{x: px_r, y: py_r, z: pz_r, label: lbl_r, link: '0};
      end
      S_LINK: begin
        dot_req.wr_en   = 1'b1;
        dot_req.wr_addr = cell_r.last;
        dot_req.wr_data = link_dot;
      end
      S_FIN: begin
        cell_req.wr_en   = here_ok_r;
        cell_req.wr_addr = here_slot_r;
        cell_req.wr_data = fin_cell;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      dots_r      <= '0;
      out_valid_r <= 1'b0;
      got_r       <= 1'b0;
      here_ok_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SLOT_W'(1);
          if (clr_r == SLOT_W'(CELL_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_data.operation;
            px_r  <= in_data.v0_x;
            py_r  <= in_data.v0_y;
            pz_r  <= in_data.v0_z;
            lbl_r <= in_data.label_region;
            ka_r  <= in_data.v0_x >>> CELL_SHIFT;
            kb_r  <= in_data.v0_y >>> CELL_SHIFT;
            kc_r  <= in_data.v0_z >>> CELL_SHIFT;
            create_r <= 1'b1;
            if (in_data.operation == OP_QUERY) begin
              state_r <= S_DIV;
            end else if (({1'b0, in_data.label_region} < (LABEL_W+1)'(REGIONS)) &&
                         (dots_r < CNT_W'(MAX_DOTS))) begin
              state_r <= S_HASH;
            end
          end
        end
        S_DIV: begin
          if (&div_done) begin
            px_r <= qx;
            py_r <= qy;
            pz_r <= qz;
            ka_r <= qx >>> CELL_SHIFT;
            kb_r <= qy >>> CELL_SHIFT;
            kc_r <= qz >>> CELL_SHIFT;
            bi_r <= qx >>> CELL_SHIFT;
            bj_r <= qy >>> CELL_SHIFT;
            bk_r <= qz >>> CELL_SHIFT;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          slot_r  <= hash_slot(ka_r, kb_r, kc_r);
          pcnt_r  <= '0;
          state_r <= S_PRD;
        end
        S_PRD: begin
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (!cell_rd.valid) begin
            hit_r   <= create_r;
            cell_r  <= fresh;
            state_r <= S_DISP;
          end else if (key_hit) begin
            hit_r   <= 1'b1;
            cell_r  <= cell_rd;
            state_r <= S_DISP;
          end else if (pcnt_r == SLOT_W'(CELL_SLOTS - 1)) begin
            hit_r   <= 1'b0;
            state_r <= S_DISP;
          end else begin
            slot_r  <= slot_r + SLOT_W'(1);
            pcnt_r  <= pcnt_r + SLOT_W'(1);
            state_r <= S_PRD;
          end
        end
        S_DISP: begin
          if (op_r == OP_LOAD) begin
            state_r <= hit_r ? S_LDWR : S_IDLE;
          end else if (create_r) begin
            here_ok_r   <= hit_r;
            here_slot_r <= slot_r;
            here_cell_r <= cell_r;
            if (hit_r && (cell_r.count != '0) && !cell_r.mixed) begin
              res_r   <= '{found: 1'b1, region: cell_r.uni};
              state_r <= S_RESP;
            end else if (hit_r && cell_r.answered) begin
              res_r   <= '{found: cell_r.ans_found, region: cell_r.ans_region};
              state_r <= S_RESP;
            end else begin
              rad_r   <= R_ONE;
              di_r    <= -R_ONE;
              dj_r    <= -R_ONE;
              dk_r    <= -R_ONE;
              got_r   <= 1'b0;
              state_r <= S_NBR;
            end
          end else if (hit_r && (cell_r.count != '0)) begin
            cur_dot_r <= cell_r.first;
            k_r       <= '0;
            state_r   <= S_DRD;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_LDWR: begin
          dots_r  <= dots_r + CNT_W'(1);
          state_r <= (cell_r.count == '0) ? S_IDLE : S_LINK;
        end
        S_LINK: begin
          state_r <= S_IDLE;
        end
        S_NBR: begin
          ka_r     <= bi_r + COORD_W'(di_r);
          kb_r     <= bj_r + COORD_W'(dj_r);
          kc_r     <= bk_r + COORD_W'(dk_r);
          create_r <= 1'b0;
          state_r  <= S_HASH;
        end
        S_DRD: begin
          state_r <= S_DMUL;
        end
        S_DMUL: begin
          sqx_r   <= SQ_W'(ex * ex);
          sqy_r   <= SQ_W'(ey * ey);
          sqz_r   <= SQ_W'(ez * ez);
          dlbl_r  <= dot_rd.label;
          dlink_r <= dot_rd.link;
          state_r <= S_DCMP;
        end
        S_DCMP: begin
          if (!got_r || (e_sum < best_d_r)) begin
            got_r    <= 1'b1;
            best_d_r <= e_sum;
            best_r_r <= dlbl_r;
          end
          if (k_r + CNT_W'(1) == cell_r.count) begin
            state_r <= S_NEXT;
          end else begin
            k_r       <= k_r + CNT_W'(1);
            cur_dot_r <= dlink_r;
            state_r   <= S_DRD;
          end
        end
        S_NEXT: begin
          state_r <= S_NBR;
          if (dk_r == rad_r) begin
            dk_r <= neg_rad;
            if (dj_r == rad_r) begin
              dj_r <= neg_rad;
              if (di_r == rad_r) begin
                if (got_r || (rad_r == R_MAX)) begin
                  state_r <= S_FIN;
                end else begin
                  rad_r <= rad_r + R_ONE;
                  di_r  <= neg_rad - R_ONE;
                  dj_r  <= neg_rad - R_ONE;
                  dk_r  <= neg_rad - R_ONE;
                end
              end else begin
                di_r <= di_r + R_ONE;
              end
            end else begin
              dj_r <= dj_r + R_ONE;
            end
          end else if (interior_ij && (dk_r == neg_rad)) begin
            dk_r <= rad_r;
          end else begin
            dk_r <= dk_r + R_ONE;
          end
        end
        S_FIN: begin
          res_r   <= '{found: got_r, region: got_r ? best_r_r : '0};
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/gnrc_checker.sv */
module gnrc_checker
  import gnrc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input dropped or changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during table clear");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.region == '0)
    else $error("region set on a not-found result");

endmodule

bind grid_nearest_region_classifier gnrc_checker u_gnrc_checker (.*);

/* dv/grid_nearest_region_classifier_tb.sv */
module grid_nearest_region_classifier_tb;
  import gnrc_pkg::*;

  localparam int STALL_LIMIT = 300000;
  localparam int CLUSTER     = 4096;

  typedef bit [71:0] cell_key_t;

  typedef struct {
    bit     mixed;
    label_t uni;
    bit     answered;
    bit     ans_found;
    label_t ans_region;
  } cell_rec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t      answer_q[$];
  int        fail_count;
  int        stall_cycles;
  bit        steady;
  bit        rx_enable;
  longint    dot_x[$];
  longint    dot_y[$];
  longint    dot_z[$];
  label_t    dot_lbl[$];
  int        cell_dots[cell_key_t][$];
  cell_rec_t cells[cell_key_t];

  grid_nearest_region_classifier u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit gap_now();
    return !steady && ($urandom_range(0, 99) < 13);
  endfunction

  function automatic in_t rand_item();
    bit [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic longint grid_of(longint v);
    return v >>> CELL_SHIFT;
  endfunction

  function automatic longint centroid_axis(longint s);
    longint q;
    q = s / 3;
    if ((s % 3 != 0) && (s < 0)) q--;
    return q;
  endfunction

  function automatic cell_key_t key_of(longint a, longint b, longint c);
    logic [23:0] ka;
    logic [23:0] kb;
    logic [23:0] kc;
    ka = a[23:0];
    kb = b[23:0];
    kc = c[23:0];
    return {ka, kb, kc};
  endfunction

  function automatic void store_dot(longint x, longint y, longint z, label_t lbl);
    cell_key_t k;
    cell_rec_t r;
    k = key_of(grid_of(x), grid_of(y), grid_of(z));
    if (!cells.exists(k)) begin
      r = '{default: 0};
      cells[k] = r;
    end
    if (!cell_dots.exists(k) || cell_dots[k].size() == 0) cells[k].uni = lbl;
    else if (cells[k].uni != lbl) cells[k].mixed = 1'b1;
    cell_dots[k].push_back(dot_x.size());
    dot_x.push_back(x);
    dot_y.push_back(y);
    dot_z.push_back(z);
    dot_lbl.push_back(lbl);
  endfunction

  function automatic out_t nearest_region(longint cx, longint cy, longint cz);
    cell_key_t home;
    cell_key_t k;
    cell_rec_t r;
    longint    bi, bj, bk, ex, ey, ez;
    longint    e, best;
    bit        got;
    out_t      res;
    int        d;
    bi = grid_of(cx);
    bj = grid_of(cy);
    bk = grid_of(cz);
    home = key_of(bi, bj, bk);
    got = 1'b0;
    best = 0;
    res = '0;
    if (!cells.exists(home)) begin
      r = '{default: 0};
      cells[home] = r;
    end
    if (cell_dots.exists(home) && cell_dots[home].size() > 0 && !cells[home].mixed) begin
      res.found = 1'b1;
      res.region = cells[home].uni;
      return res;
    end
    if (cells[home].answered) begin
      res.found = cells[home].ans_found;
      res.region = cells[home].ans_region;
      return res;
    end
    for (int rad = 1; rad <= MAX_RADIUS_DEF && !got; rad++) begin
      for (int di = -rad; di <= rad; di++)
        for (int dj = -rad; dj <= rad; dj++)
          for (int dk = -rad; dk <= rad; dk++) begin
            if (rad > 1 && di > -rad && di < rad && dj > -rad && dj < rad &&
                dk > -rad && dk < rad) continue;
            k = key_of(bi + di, bj + dj, bk + dk);
            if (!cell_dots.exists(k)) continue;
            for (int n = 0; n < cell_dots[k].size(); n++) begin
              d = cell_dots[k][n];
              ex = cx - dot_x[d];
              ey = cy - dot_y[d];
              ez = cz - dot_z[d];
              e = ex * ex + ey * ey + ez * ez;
              if (!got || e < best) begin
                got = 1'b1;
                best = e;
                res.region = dot_lbl[d];
              end
            end
          end
    end
    res.found = got;
    if (!got) res.region = '0;
    cells[home].answered = 1'b1;
    cells[home].ans_found = res.found;
    cells[home].ans_region = res.region;
    return res;
  endfunction

  function automatic void predict(in_t it);
    if (it.operation == OP_LOAD) begin
      store_dot(longint'(it.v0_x), longint'(it.v0_y), longint'(it.v0_z), it.label_region);
    end else begin
      answer_q.push_back(nearest_region(
        centroid_axis(longint'(it.v0_x) + it.v1_x + it.v2_x),
        centroid_axis(longint'(it.v0_y) + it.v1_y + it.v2_y),
        centroid_axis(longint'(it.v0_z) + it.v1_z + it.v2_z)));
    end
  endfunction

  task automatic send_item(in_t it);
    if (gap_now()) begin
      in_valid <= 1'b0;
      in_data  <= rand_item();
      do @(negedge clk); while (gap_now());
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
    @(negedge clk);
  endtask

  task automatic load_dot(coord_t x, coord_t y, coord_t z, label_t lbl);
    in_t it;
    it = rand_item();
    it.operation = OP_LOAD;
    it.v0_x = x;
    it.v0_y = y;
    it.v0_z = z;
    it.label_region = lbl;
    send_item(it);
  endtask

  task automatic query_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                           coord_t bz, coord_t cx, coord_t cy, coord_t cz);
    in_t it;
    it = rand_item();
    it.operation = OP_QUERY;
    it.v0_x = ax; it.v0_y = ay; it.v0_z = az;
    it.v1_x = bx; it.v1_y = by; it.v1_z = bz;
    it.v2_x = cx; it.v2_y = cy; it.v2_z = cz;
    send_item(it);
  endtask

  task automatic query_at(coord_t x, coord_t y, coord_t z);
    query_tri(x, y, z, x, y, z, x, y, z);
  endtask

  // random triangle whose centroid lands on the target point
  task automatic query_near(longint x, longint y, longint z);
    longint o[6];
    longint r;
    foreach (o[i]) o[i] = longint'($urandom_range(0, 4194303)) - 2097152;
    r = $urandom_range(0, 2);
    query_tri(coord_t'(x + o[0]), coord_t'(y + o[1]), coord_t'(z + o[2]),
              coord_t'(x + o[3]), coord_t'(y + o[4]), coord_t'(z + o[5]),
              coord_t'(3 * x + r - 2 * x - o[0] - o[3]),
              coord_t'(3 * y + r - 2 * y - o[1] - o[4]),
              coord_t'(3 * z + r - 2 * z - o[2] - o[5]));
  endtask

  task automatic test_empty_and_extremes();
    query_at(0, 0, 0);
    load_dot(-24'sd8388608, -24'sd8388608, -24'sd8388608, 6'd63);
    load_dot(24'sd8388607, 24'sd8388607, 24'sd8388607, 6'd0);
    query_at(-24'sd8388608, -24'sd8388608, -24'sd8388608);
    query_at(24'sd8388607, 24'sd8388607, 24'sd8388607);
    query_tri(24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607,
              24'sd8388607, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    query_tri(-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608,
              -24'sd8388608, -24'sd8388608, -24'sd8388607, 24'sd1, -24'sd1);
    query_tri(-24'sd1, -24'sd2, -24'sd4, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_tie_order();
    load_dot(24'sd100256, 24'sd100768, 24'sd100256, 6'd5);
    load_dot(24'sd99744, 24'sd100256, 24'sd100256, 6'd7);
    load_dot(24'sd100768, 24'sd100256, 24'sd100256, 6'd6);
    query_at(24'sd100256, 24'sd100256, 24'sd100256);
    load_dot(24'sd120000, 24'sd120000, 24'sd120000, 6'd11);
    load_dot(24'sd120000, 24'sd120000, 24'sd120000, 6'd12);
    query_at(24'sd119400, 24'sd120000, 24'sd120000);
  endtask

  task automatic test_stored_answer();
    query_at(-24'sd200000, 24'sd200000, -24'sd200000);
    load_dot(-24'sd199488, 24'sd200000, -24'sd200000, 6'd3);
    query_at(-24'sd200000, 24'sd200000, -24'sd200000);
    load_dot(-24'sd200000, 24'sd200000, -24'sd200000, 6'd9);
    query_at(-24'sd200000, 24'sd200000, -24'sd200000);
    load_dot(-24'sd200000, 24'sd200000, -24'sd200000, 6'd10);
    query_at(-24'sd200000, 24'sd200000, -24'sd200000);
  endtask

  task automatic test_random(int n);
    in_t    it;
    longint x, y, z;
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 3) && (i < n / 2);
      x = longint'($urandom_range(0, 2 * CLUSTER)) - CLUSTER;
      y = longint'($urandom_range(0, 2 * CLUSTER)) - CLUSTER;
      z = longint'($urandom_range(0, 2 * CLUSTER)) - CLUSTER;
      case ($urandom_range(0, 19))
        0: begin
          it = rand_item();
          send_item(it);
        end
        1, 2, 3, 4, 5, 6, 7:
          load_dot(coord_t'(x), coord_t'(y), coord_t'(z),
                   ($urandom_range(0, 3) == 0) ? label_t'($urandom) :
                                                 label_t'($urandom_range(0, 3)));
        default: query_near(x * 2, y * 2, z * 2);
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= rx_enable && !gap_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result transfer with nothing expected: found=%0b region=%0d",
               out_data.found, out_data.region);
        fail_count++;
      end else begin
        if (out_data.found !== answer_q[0].found) begin
          $error("found: expected %0b actual %0b", answer_q[0].found, out_data.found);
          fail_count++;
        end
        if (out_data.region !== answer_q[0].region) begin
          $error("region: expected %0d actual %0d", answer_q[0].region, out_data.region);
          fail_count++;
        end
        void'(answer_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL grid_nearest_region_classifier");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    stall_cycles = 0;
    steady = 1'b0;
    rx_enable = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    rx_enable = 1'b1;
    test_empty_and_extremes();
    test_tie_order();
    test_stored_answer();
    test_random(1780);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS grid_nearest_region_classifier");
    end else begin
      $display("FAIL grid_nearest_region_classifier");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/gnrc_pkg.sv
hdl/gnrc_cell_mem.sv
hdl/gnrc_dot_mem.sv
hdl/gnrc_div3.sv
hdl/grid_nearest_region_classifier.sv
hdl/gnrc_checker.sv
dv/grid_nearest_region_classifier_tb.sv
